FILE: rtl/apm_pkg.sv
package apm_pkg;

  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned BLOCK_SHIFT     = 6;
  localparam int unsigned BLK_W           = ADDR_W - BLOCK_SHIFT;
  localparam int unsigned BLOCKS_PER_PAGE = 64;
  localparam int unsigned OFF_W           = $clog2(BLOCKS_PER_PAGE);
  localparam int unsigned PAGE_W          = BLK_W - OFF_W;
  localparam int unsigned MAX_STRIDE      = 16;
  localparam int unsigned STRIDE_W        = $clog2(MAX_STRIDE + 1);
  localparam int unsigned MAX_RESULTS     = 8;
  localparam int unsigned RES_W           = $clog2(MAX_RESULTS + 1);

  localparam int unsigned DEF_PAGE_DEPTH  = 64;
  localparam int unsigned DEF_QUEUE_DEPTH = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned PT_W       = 7;
  localparam int unsigned PRED_W     = 6;
  localparam int unsigned PF_W       = 4;
  localparam int unsigned QL_W       = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGES_TRACKED,
    CFG_PRED_DEGREE,
    CFG_PF_DEGREE,
    CFG_QUEUE_LIMIT
  } cfg_reg_e;

  localparam logic [PT_W-1:0]   RST_PAGES_TRACKED = 7'd64;
  localparam logic [PRED_W-1:0] RST_PRED_DEGREE   = 6'd4;
  localparam logic [PF_W-1:0]   RST_PF_DEGREE     = 4'd4;
  localparam logic [QL_W-1:0]   RST_QUEUE_LIMIT   = 6'd32;

  typedef enum logic [1:0] {
    PG_IDLE,
    PG_SCAN,
    PG_DECIDE,
    PG_UPDATE
  } page_state_e;

  typedef enum logic [1:0] {
    QU_IDLE,
    QU_DUP,
    QU_POP
  } queue_state_e;

  typedef enum logic [2:0] {
    CT_IDLE,
    CT_PAGE,
    CT_CAND,
    CT_INS,
    CT_POP,
    CT_POP_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic              start;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
  } page_req_t;

  typedef struct packed {
    logic                       done;
    logic [BLOCKS_PER_PAGE-1:0] map;
  } page_rsp_t;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [BLK_W-1:0] block;
    logic [QL_W-1:0]  limit;
  } queue_req_t;

  typedef struct packed {
    logic             done;
    logic             dropped;
    logic             valid;
    logic [BLK_W-1:0] block;
  } queue_rsp_t;

endpackage

FILE: rtl/apm_if.sv
interface apm_in_if import apm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface apm_out_if import apm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] prefetch_address;
  logic              address_valid;
  logic              last;

  modport source (output valid, output prefetch_address, output address_valid,
                  output last, input ready);
  modport sink (input valid, input prefetch_address, input address_valid,
                input last, output ready);
endinterface

FILE: rtl/apm_page_table.sv
module apm_page_table import apm_pkg::*; #(
  parameter int unsigned DEPTH = DEF_PAGE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  page_req_t       req_i,
  input  logic [PT_W-1:0] pages_tracked_i,
  output page_rsp_t       rsp_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = 9;

  typedef struct packed {
    logic [PAGE_W-1:0]          tag;
    logic [IW-1:0]              rank;
    logic [BLOCKS_PER_PAGE-1:0] map;
  } entry_t;

  entry_t page_mem [DEPTH];

  page_state_e       state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              cmp_vld_q;
  logic [IW-1:0]     cmp_idx_q;
  entry_t            rd_q;
  logic [DEPTH-1:0]  valid_q, valid_d;
  logic              done_q;
  logic [PAGE_W-1:0] page_q;
  logic [OFF_W-1:0]  off_q;
  logic              hit_found_q, vic_found_q, free_found_q, was_hit_q;
  logic [IW-1:0]     hit_idx_q, old_rank_q, vic_idx_q, vic_rank_q, free_idx_q, e_q;
  logic [CW-1:0]     held_q;
  logic [BLOCKS_PER_PAGE-1:0] map_q;

  logic          rd_en, last_cmp, scan_v, ent_valid;
  logic          tag_hit, take_vic, take_free, evict, we;
  logic [IW-1:0] ra, slot, e_sel;
  logic [LW-1:0] limit;
  entry_t        wd;

  assign last_cmp  = cmp_vld_q && (cmp_idx_q == IW'(DEPTH - 1));
  assign scan_v    = (state_q == PG_SCAN) && cmp_vld_q;
  assign ent_valid = valid_q[cmp_idx_q];
  assign tag_hit   = scan_v && ent_valid && (rd_q.tag == page_q) && !hit_found_q;
  assign take_vic  = scan_v && ent_valid && (!vic_found_q || (rd_q.rank > vic_rank_q));
  assign take_free = scan_v && !ent_valid && !free_found_q;

  // eviction decision from the scan results
  always_comb begin
    if (pages_tracked_i == '0) begin
      limit = LW'(1);
    end else if (LW'(pages_tracked_i) > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = LW'(pages_tracked_i);
    end
    evict = !hit_found_q && (LW'(held_q) >= limit);
    if (free_found_q) begin
      slot = (evict && (vic_idx_q < free_idx_q)) ? vic_idx_q : free_idx_q;
    end else begin
      slot = evict ? vic_idx_q : '0;
    end
    e_sel = hit_found_q ? hit_idx_q : slot;
    valid_d = valid_q;
    if (evict) valid_d[vic_idx_q] = 1'b0;
    valid_d[e_sel] = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      PG_IDLE: begin
        if (req_i.start) begin
          state_d = PG_SCAN;
          cnt_d   = '0;
        end
      end
      PG_SCAN: begin
        if (rd_en) cnt_d = cnt_q + 1'b1;
        if (last_cmp) state_d = PG_DECIDE;
      end
      PG_DECIDE: begin
        state_d = PG_UPDATE;
        cnt_d   = '0;
      end
      PG_UPDATE: begin
        if (rd_en) cnt_d = cnt_q + 1'b1;
        if (last_cmp) state_d = PG_IDLE;
      end
      default: state_d = PG_IDLE;
    endcase
  end

  // memory port control and write-back word
  always_comb begin
    rd_en = ((state_q == PG_SCAN) || (state_q == PG_UPDATE)) && (cnt_q < CW'(DEPTH));
    ra    = cnt_q[IW-1:0];
    we    = (state_q == PG_UPDATE) && cmp_vld_q;
    wd    = rd_q;
    if (cmp_idx_q == e_q) begin
      wd.tag  = page_q;
      wd.rank = '0;
      wd.map  = (was_hit_q ? rd_q.map : '0) | (BLOCKS_PER_PAGE'(1) << off_q);
    end else if (ent_valid && (!was_hit_q || (rd_q.rank < old_rank_q))) begin
      wd.rank = rd_q.rank + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= page_mem[ra];
    if (we) page_mem[cmp_idx_q] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= PG_IDLE;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      valid_q      <= '0;
      done_q       <= 1'b0;
      hit_found_q  <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      held_q       <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= rd_en;
      done_q    <= (state_q == PG_UPDATE) && last_cmp;
      if ((state_q == PG_IDLE) && req_i.start) begin
        hit_found_q  <= 1'b0;
        vic_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        held_q       <= '0;
      end
      if (tag_hit) hit_found_q <= 1'b1;
      if (take_vic) vic_found_q <= 1'b1;
      if (take_free) free_found_q <= 1'b1;
      if (scan_v && ent_valid) held_q <= held_q + 1'b1;
      if (state_q == PG_DECIDE) valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= ra;
    if ((state_q == PG_IDLE) && req_i.start) begin
      page_q <= req_i.page;
      off_q  <= req_i.off;
    end
    if (tag_hit) begin
      hit_idx_q  <= cmp_idx_q;
      old_rank_q <= rd_q.rank;
    end
    if (take_vic) begin
      vic_idx_q  <= cmp_idx_q;
      vic_rank_q <= rd_q.rank;
    end
    if (take_free) free_idx_q <= cmp_idx_q;
    if (state_q == PG_DECIDE) begin
      e_q       <= e_sel;
      was_hit_q <= hit_found_q;
    end
    if (we && (cmp_idx_q == e_q)) map_q <= wd.map;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.map  = map_q;

endmodule

FILE: rtl/apm_pf_queue.sv
module apm_pf_queue import apm_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  queue_req_t req_i,
  output queue_rsp_t rsp_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned LW = 9;

  logic [BLK_W-1:0] q_mem [DEPTH];

  queue_state_e     state_q, state_d;
  logic [IW-1:0]    head_q;
  logic [CW-1:0]    count_q, j_q;
  logic             cmp_vld_q;
  logic [BLK_W-1:0] rd_q, blk_q;

  logic          rd_en, we, match, sweep_end, full;
  logic [IW-1:0] ra, wa;
  logic [LW-1:0] lim;

  // circular index: base plus offset, wrapped once
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base, input logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[IW-1:0];
  endfunction

  assign lim       = (LW'(req_i.limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(req_i.limit);
  assign full      = LW'(count_q) >= lim;
  assign match     = cmp_vld_q && (rd_q == blk_q);
  assign sweep_end = (j_q == count_q) && !cmp_vld_q;
  assign wa        = wrap(head_q, count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      QU_IDLE: begin
        if (req_i.ins) state_d = QU_DUP;
        else if (req_i.pop) state_d = QU_POP;
      end
      QU_DUP:  if (match || sweep_end) state_d = QU_IDLE;
      QU_POP:  state_d = QU_IDLE;
      default: state_d = QU_IDLE;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    ra            = head_q;
    we            = 1'b0;
    rsp_o.done    = 1'b0;
    rsp_o.dropped = 1'b0;
    rsp_o.valid   = 1'b0;
    rsp_o.block   = rd_q;
    case (state_q)
      QU_IDLE: rd_en = req_i.pop && !req_i.ins;
      QU_DUP: begin
        rd_en = (j_q < count_q) && !match;
        ra    = wrap(head_q, j_q);
        if (match) begin
          rsp_o.done = 1'b1;
        end else if (sweep_end) begin
          rsp_o.done    = 1'b1;
          rsp_o.dropped = full;
          we            = !full;
        end
      end
      QU_POP: begin
        rsp_o.done  = 1'b1;
        rsp_o.valid = count_q != '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= q_mem[ra];
    if (we) q_mem[wa] <= blk_q;
    if ((state_q == QU_IDLE) && req_i.ins) blk_q <= req_i.block;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= QU_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      j_q       <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en && (state_q == QU_DUP);
      if (state_q == QU_IDLE) j_q <= '0;
      else if (rd_en) j_q <= j_q + 1'b1;
      if (we) count_q <= count_q + 1'b1;
      if ((state_q == QU_POP) && (count_q != '0)) begin
        head_q  <= wrap(head_q, CW'(1));
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/access_map_pattern_prefetcher.sv
// Access map pattern prefetcher.
// in_ch (sink) takes one demand byte address per item; out_ch (source) gives
// prefetch_degree result items per demand (up to 8), the final one flagged
// by last. A result with address_valid low means the prefetch queue was empty.
// The cfg port writes pages_tracked, prediction_degree, prefetch_degree and
// queue_limit by index; write only while the block is idle.
// Per item: two sweeps of the page memory, one entry per cycle, each with a
// registered read, then the strides are tested in turn (up to 32), plus for
// each candidate a queue sweep for the duplicate check, and one queue pop per
// result before the block goes idle. The page memory sweeps and the queue's
// single read port set how long an item takes.
// in_ch.ready is high only between items. Results pass through one output
// register: a stalled receiver holds the register and the block waits before
// popping the next queue entry; the next demand is taken only once the
// controller has gone from CT_POP_WAIT through CT_POP back to idle.
// Reset clears page valid bits, queue pointers and config to defaults; page
// and queue memories need no clearing pass.
module access_map_pattern_prefetcher import apm_pkg::*; #(
  parameter int unsigned PAGE_BUFFER_DEPTH    = DEF_PAGE_DEPTH,
  parameter int unsigned PREFETCH_QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  apm_in_if.sink                in_ch,
  apm_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration
  logic [PT_W-1:0]   pt_q;
  logic [PRED_W-1:0] pred_q;
  logic [PF_W-1:0]   pf_q;
  logic [QL_W-1:0]   ql_q;

  ctrl_state_e state_q, state_d;

  logic [PAGE_W-1:0]          page_q;
  logic [OFF_W-1:0]           off_q;
  logic [BLOCKS_PER_PAGE-1:0] map_q;
  logic [STRIDE_W-1:0]        s_q;
  logic                       dir_q;      // 0 forward, 1 backward
  logic                       strides_done_q;
  logic [PRED_W-1:0]          ncand_q;
  logic [RES_W-1:0]           k_q;

  logic              out_vld_q, out_av_q, out_last_q;
  logic [ADDR_W-1:0] out_addr_q;

  page_req_t  page_req;
  page_rsp_t  page_rsp;
  queue_req_t q_req;
  queue_rsp_t q_rsp;

  logic             in_take, out_take, cand_hit, pred_full;
  logic [6:0]       off7, s7, s2, ia, ib, ic, id;
  logic [OFF_W-1:0] cand_off;
  logic [RES_W-1:0] n_res;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;

  apm_page_table #(
    .DEPTH (PAGE_BUFFER_DEPTH)
  ) u_pages (
    .clk_i,
    .rst_ni,
    .req_i           (page_req),
    .pages_tracked_i (pt_q),
    .rsp_o           (page_rsp)
  );

  apm_pf_queue #(
    .DEPTH (PREFETCH_QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .req_i (q_req),
    .rsp_o (q_rsp)
  );

  // stride test: forward needs blocks off-s and off-2s, backward off+s and off+2s
  always_comb begin
    off7 = 7'(off_q);
    s7   = 7'(s_q);
    s2   = s7 << 1;
    ia   = off7 - s7;
    ib   = off7 - s2;
    ic   = off7 + s7;
    id   = off7 + s2;
    if (!dir_q) begin
      cand_hit = (off7 >= s2) && map_q[ia[OFF_W-1:0]] && map_q[ib[OFF_W-1:0]]
                 && (ic < 7'(BLOCKS_PER_PAGE));
      cand_off = ic[OFF_W-1:0];
    end else begin
      cand_hit = (id < 7'(BLOCKS_PER_PAGE)) && map_q[ic[OFF_W-1:0]] && map_q[id[OFF_W-1:0]]
                 && (off7 >= s7);
      cand_off = ia[OFF_W-1:0];
    end
  end

  assign pred_full = (ncand_q >= pred_q) || strides_done_q;
  assign n_res     = (RES_W'(pf_q) > RES_W'(MAX_RESULTS)) ? RES_W'(MAX_RESULTS) : RES_W'(pf_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      CT_IDLE: if (in_take) state_d = CT_PAGE;
      CT_PAGE: if (page_rsp.done) state_d = CT_CAND;
      CT_CAND: begin
        if (pred_full) state_d = CT_POP;
        else if (cand_hit) state_d = CT_INS;
      end
      CT_INS: begin
        if (q_rsp.done) state_d = q_rsp.dropped ? CT_POP : CT_CAND;
      end
      CT_POP: begin
        if (k_q >= n_res) state_d = CT_IDLE;
        else if (!out_vld_q || out_take) state_d = CT_POP_WAIT;
      end
      CT_POP_WAIT: if (q_rsp.done) state_d = CT_POP;
      default: state_d = CT_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = state_q == CT_IDLE;
    page_req.start = in_take;
    page_req.page  = in_ch.address[ADDR_W-1 -: PAGE_W];
    page_req.off   = in_ch.address[BLOCK_SHIFT +: OFF_W];
    q_req.ins      = (state_q == CT_CAND) && !pred_full && cand_hit;
    q_req.pop      = (state_q == CT_POP) && (k_q < n_res) && (!out_vld_q || out_take);
    q_req.block    = {page_q, cand_off};
    q_req.limit    = ql_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q      <= RST_PAGES_TRACKED;
      pred_q    <= RST_PRED_DEGREE;
      pf_q      <= RST_PF_DEGREE;
      ql_q      <= RST_QUEUE_LIMIT;
      state_q   <= CT_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_PAGES_TRACKED: pt_q   <= cfg_data_i[PT_W-1:0];
          CFG_PRED_DEGREE:   pred_q <= cfg_data_i[PRED_W-1:0];
          CFG_PF_DEGREE:     pf_q   <= cfg_data_i[PF_W-1:0];
          CFG_QUEUE_LIMIT:   ql_q   <= cfg_data_i[QL_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == CT_POP_WAIT) && q_rsp.done) out_vld_q <= 1'b1;
      else if (out_take) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      page_q <= page_req.page;
      off_q  <= page_req.off;
    end
    if ((state_q == CT_PAGE) && page_rsp.done) begin
      map_q          <= page_rsp.map;
      s_q            <= STRIDE_W'(MAX_STRIDE);
      dir_q          <= 1'b0;
      strides_done_q <= 1'b0;
      ncand_q        <= '0;
      k_q            <= '0;
    end
    if ((state_q == CT_CAND) && !pred_full) begin
      if (cand_hit) ncand_q <= ncand_q + 1'b1;
      if (s_q == STRIDE_W'(1)) begin
        if (dir_q) begin
          strides_done_q <= 1'b1;
        end else begin
          dir_q <= 1'b1;
          s_q   <= STRIDE_W'(MAX_STRIDE);
        end
      end else begin
        s_q <= s_q - 1'b1;
      end
    end
    if ((state_q == CT_POP_WAIT) && q_rsp.done) begin
      out_addr_q <= q_rsp.valid ? {q_rsp.block, {BLOCK_SHIFT{1'b0}}} : '0;
      out_av_q   <= q_rsp.valid;
      out_last_q <= (k_q + 1'b1) == n_res;
      k_q        <= k_q + 1'b1;
    end
  end

  assign out_ch.valid            = out_vld_q;
  assign out_ch.prefetch_address = out_addr_q;
  assign out_ch.address_valid    = out_av_q;
  assign out_ch.last             = out_last_q;

  // a taken demand always starts the page lookup
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == CT_PAGE)
    else $error("demand taken but page lookup not started");

  // a pop is only issued when the output register can take its result
  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_req.pop |-> (!out_vld_q || out_take))
    else $error("pop issued with output register occupied");

  a_queue_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rsp.done |-> (state_q == CT_INS || state_q == CT_POP_WAIT))
    else $error("unexpected queue response");

  a_page_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_rsp.done |-> state_q == CT_PAGE)
    else $error("unexpected page table response");

endmodule
